// ----- hw/rtl/itoa_pkg.sv -----
package itoa_pkg;

    // Word size of the integer being converted.
    localparam int WORD_BITS = 32;

    // Characters emitted by the block.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Radix selector carried in tuser.
    localparam logic KIND_DEC = 1'b0;
    localparam logic KIND_OCT = 1'b1;

    // Longest digit run: eleven octal digits for a 32-bit word.
    localparam int STACK_DEPTH = 11;
    localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
    localparam int STACK_CNT_W = $clog2(STACK_DEPTH + 1);

    // Reciprocal of ten: q = (v * RECIP_TEN) >> RECIP_SHIFT is exact for 32-bit v.
    localparam logic [WORD_BITS-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int                   RECIP_SHIFT = 35;
    localparam int                   PROD_W      = 2 * WORD_BITS;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [3:0]           digit_t;

    // Result of one pass through the shared divide unit.
    typedef struct packed {
        word_t  quot;
        digit_t rem;
    } div_result_t;

    // Control from the sequencer to the digit stack.
    typedef struct packed {
        logic   push;
        logic   pop;
        digit_t digit;
    } stack_ctl_t;

endpackage

// ----- hw/rtl/itoa_div_unit.sv -----
module itoa_div_unit
(
    input  logic                  clk,
    input  logic                  kind,
    input  itoa_pkg::word_t       mag,
    output itoa_pkg::div_result_t result
);

    logic [itoa_pkg::PROD_W-1:0] prod_reg;
    logic [itoa_pkg::PROD_W-1:0] prod_next;
    itoa_pkg::word_t             dec_quot;
    itoa_pkg::word_t             dec_times_ten;
    itoa_pkg::word_t             dec_diff;

    // The reciprocal product is registered; the decimal result is read in the
    // cycle after the magnitude is presented, while the magnitude holds.
    assign prod_next = {{itoa_pkg::WORD_BITS{1'b0}}, mag}
                     * {{itoa_pkg::WORD_BITS{1'b0}}, itoa_pkg::RECIP_TEN};

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign dec_quot = itoa_pkg::word_t'(prod_reg >> itoa_pkg::RECIP_SHIFT);
    assign dec_times_ten = (dec_quot << 3) + (dec_quot << 1);
    assign dec_diff = mag - dec_times_ten;

    always_comb
    begin
        if (kind == itoa_pkg::KIND_OCT)
        begin
            result.quot = mag >> 3;
            result.rem  = {1'b0, mag[2:0]};
        end
        else
        begin
            result.quot = dec_quot;
            result.rem  = dec_diff[3:0];
        end
    end

endmodule

// ----- hw/rtl/itoa_digit_stack.sv -----
module itoa_digit_stack
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  itoa_pkg::stack_ctl_t               ctl,
    output itoa_pkg::digit_t                   top_digit,
    output logic [itoa_pkg::STACK_CNT_W-1:0]   count
);

    itoa_pkg::digit_t                   mem [itoa_pkg::STACK_DEPTH];
    logic [itoa_pkg::STACK_CNT_W-1:0]   count_reg;
    logic [itoa_pkg::STACK_CNT_W-1:0]   count_next;
    logic [itoa_pkg::STACK_CNT_W-1:0]   below_pos;
    itoa_pkg::digit_t                   top_reg;

    assign below_pos = count_reg - itoa_pkg::STACK_CNT_W'(2);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The top entry is held in a register: a push loads the new digit
    // directly, and a pop reads the entry just below the current top.
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[count_reg[itoa_pkg::STACK_IDX_W-1:0]] <= ctl.digit;
            top_reg                                   <= ctl.digit;
        end
        else if (ctl.pop && (count_reg > itoa_pkg::STACK_CNT_W'(1)))
        begin
            top_reg <= mem[below_pos[itoa_pkg::STACK_IDX_W-1:0]];
        end
    end

    assign top_digit = top_reg;
    assign count     = count_reg;

endmodule

// ----- hw/rtl/integer_to_ascii_digits.sv -----
// Converts one 32-bit word per input transaction into a run of ASCII
// characters, one output transaction per character, with tlast on the final
// character. tuser selects the format: 0 reads tdata as a two's complement
// integer and emits a '-' for negative values followed by the decimal digits
// of the magnitude (the most negative value is emitted in full), 1 reads
// tdata as unsigned and emits its octal digits. Digits come most significant
// first with no leading zeros, and zero gives a single '0'. The block takes
// one number at a time: tready is low from acceptance until the last
// character has been loaded into the output register. A shared divide unit
// peels off one digit per pass, least significant first, into a digit stack
// that is then popped toward the output. A decimal digit takes a step for the
// registered reciprocal product and a step for the remainder, while an octal
// digit is split off directly. Emission then runs at one character per
// cycle, the sign included, while the sink keeps tready high.
module integer_to_ascii_digits
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] digit_char
    output logic        m_tlast    // last
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SPLIT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                            state_reg;
    state_t                            state_next;
    itoa_pkg::word_t                   mag_reg;
    itoa_pkg::word_t                   mag_next;
    logic                              neg_reg;
    logic                              neg_next;
    logic                              kind_reg;
    logic                              kind_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic [7:0]                        out_data_reg;
    logic [7:0]                        out_data_next;
    logic                              out_last_reg;
    logic                              out_last_next;

    logic                              in_accept;
    logic                              out_free;
    logic                              in_neg;
    itoa_pkg::div_result_t             div_res;
    itoa_pkg::stack_ctl_t              stk_ctl;
    itoa_pkg::digit_t                  stk_top;
    logic [itoa_pkg::STACK_CNT_W-1:0]  stk_count;

    itoa_div_unit u_div
    (
        .clk    (clk),
        .kind   (kind_reg),
        .mag    (mag_reg),
        .result (div_res)
    );

    itoa_digit_stack u_stack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (stk_ctl),
        .top_digit (stk_top),
        .count     (stk_count)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign in_neg    = (s_tuser == itoa_pkg::KIND_DEC) && s_tdata[itoa_pkg::WORD_BITS-1];

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        kind_next      = kind_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        stk_ctl.push   = 1'b0;
        stk_ctl.pop    = 1'b0;
        stk_ctl.digit  = div_res.rem;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    kind_next = s_tuser;
                    neg_next  = in_neg;
                    // Two's complement negation yields the true magnitude,
                    // including for the most negative value.
                    mag_next  = in_neg ? (~s_tdata + 1'b1) : s_tdata;
                    state_next = (s_tuser == itoa_pkg::KIND_OCT) ? ST_SPLIT : ST_MUL;
                end
            end
            ST_MUL:
            begin
                // The divide unit captures the reciprocal product this cycle.
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                stk_ctl.push = 1'b1;
                mag_next     = div_res.quot;
                if (div_res.quot == '0)
                begin
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
                else
                begin
                    state_next = (kind_reg == itoa_pkg::KIND_OCT) ? ST_SPLIT : ST_MUL;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = itoa_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    stk_ctl.pop    = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = itoa_pkg::CHAR_ZERO + {4'b0000, stk_top};
                    out_last_next  = (stk_count == itoa_pkg::STACK_CNT_W'(1));
                    if (stk_count == itoa_pkg::STACK_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            kind_reg      <= itoa_pkg::KIND_DEC;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            neg_reg       <= neg_next;
            kind_reg      <= kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // A new number is only taken once the previous run has left the stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (stk_count == '0))
        else $error("input ready while digits remain on the stack");

    // The stack never grows past its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_ctl.push |-> (stk_count < itoa_pkg::STACK_CNT_W'(itoa_pkg::STACK_DEPTH)))
        else $error("digit stack overflow");

    // Every character shown is a minus sign or a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata == itoa_pkg::CHAR_MINUS)
                   || ((m_tdata >= itoa_pkg::CHAR_ZERO) && (m_tdata <= 8'h39))))
        else $error("output character out of range");

    // Accepting a number takes the block out of its idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice without a conversion");

    // A minus sign is never the final character of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata == itoa_pkg::CHAR_MINUS)) |-> !m_tlast)
        else $error("run ends on a minus sign");

endmodule

// ----- sim/itoa_digit_checker.sv -----
module itoa_digit_checker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] kind

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] digit_char
    input  logic        m_tlast,   // last

    output int          mismatches,
    output int          chars_owed
);

    localparam logic [itoa_pkg::WORD_BITS-1:0] DEC_RADIX  = itoa_pkg::WORD_BITS'(10);
    localparam int                             OCT_GROUPS = (itoa_pkg::WORD_BITS + 2) / 3;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } digit_char_t;

    digit_char_t owed_chars[$];
    int          fail_count = 0;
    int          owed_count = 0;

    assign mismatches = fail_count;
    assign chars_owed = owed_count;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $time, what);
        fail_count++;
    endtask

    // Builds the character run for one number and queues it, sign first and
    // then digits from the most significant one down.
    function automatic void predict_digits(input logic kind,
                                           input logic [itoa_pkg::WORD_BITS-1:0] value);
        logic [itoa_pkg::WORD_BITS-1:0] mag;
        logic [7:0]                     run [$];
        logic [7:0]                     rev [0:OCT_GROUPS-1];
        logic [2:0]                     group;
        int                             n;
        int                             top_group;
        digit_char_t                    item;

        if (kind == itoa_pkg::KIND_OCT) begin
            top_group = 0;
            for (int g = 0; g < OCT_GROUPS; g++)
            begin
                group = 3'(value >> (3 * g));
                if (group != 3'd0)
                    top_group = g;
            end
            for (int g = top_group; g >= 0; g--)
                run.push_back(itoa_pkg::CHAR_ZERO + 8'(3'(value >> (3 * g))));
        end
        else
        begin
            mag = value;
            if (value[itoa_pkg::WORD_BITS-1])
            begin
                run.push_back(itoa_pkg::CHAR_MINUS);
                mag = -value;
            end
            // Decimal digits fall out least significant first.
            n = 0;
            do
            begin
                rev[n] = itoa_pkg::CHAR_ZERO + 8'(mag % DEC_RADIX);
                mag = mag / DEC_RADIX;
                n++;
            end while (mag != 0);
            for (int i = n - 1; i >= 0; i--)
                run.push_back(rev[i]);
        end

        foreach (run[i])
        begin
            item.ch   = run[i];
            item.last = (i == run.size() - 1);
            owed_chars.push_back(item);
        end
    endfunction

    always @(posedge clk)
    begin
        digit_char_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_digits(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
            begin
                if (owed_chars.size() == 0)
                    report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                              m_tdata, m_tlast));
                else
                begin
                    want = owed_chars.pop_front();
                    if (m_tdata !== want.ch)
                        report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                                  m_tdata, want.ch));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("tlast %0b on char 0x%02h, expected %0b",
                                                  m_tlast, want.ch, want.last));
                end
            end
            owed_count <= owed_chars.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
module tb;

    // No transaction on either side for this many cycles means the block is hung.
    // The limit must cover the slowest number's work plus receiver stalls.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 107;
    localparam int DRAIN_CYCLES   = 40;

    logic        clk;
    logic        rst_n     = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;    // [31:0] value
    logic        s_tuser   = 1'b0;  // [0] kind

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] digit_char
    logic        m_tlast;           // last

    int          mismatches;
    int          chars_owed;

    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          ready_odds  = 4;
    int          stall_phase = 0;

    integer_to_ascii_digits u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    itoa_digit_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The sink changes its mood periodically: from always ready down to
    // ready only one cycle in four, so stalls can land on any character of a run.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 63)
            ready_odds <= $urandom_range(1, 4);
        m_tready <= ($urandom_range(1, 4) <= ready_odds);
    end

    // Counts cycles in which neither side completes a transaction.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Presents one number and holds it until the block takes it. The sender
    // works in bursts; between bursts it drops tvalid for a random gap, and
    // some gaps are zero so that long back-to-back stretches occur too.
    task automatic send_number(input logic kind, input logic [31:0] value);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // Holds the sender off until every character owed so far has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_owed != 0)
            @(posedge clk);
    endtask

    // Mixes magnitudes so that both short and full-length runs are common,
    // and negates a share of them to get small negative decimals.
    function automatic logic [31:0] random_word();
        int          bits;
        logic [31:0] word;
        bits = $urandom_range(1, 32);
        word = $urandom;
        if (bits < 32)
            word = word & ((32'd1 << bits) - 32'd1);
        if ($urandom_range(0, 5) == 0)
            word = -word;
        return word;
    endfunction

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in both formats, single digits and the first carries into a new digit.
        send_number(itoa_pkg::KIND_DEC, 32'd0);
        send_number(itoa_pkg::KIND_OCT, 32'd0);
        send_number(itoa_pkg::KIND_DEC, 32'd9);
        send_number(itoa_pkg::KIND_DEC, 32'd10);
        send_number(itoa_pkg::KIND_DEC, 32'd99);
        send_number(itoa_pkg::KIND_DEC, 32'd100);
        send_number(itoa_pkg::KIND_OCT, 32'd7);
        send_number(itoa_pkg::KIND_OCT, 32'd8);
        // Negative values, down to the most negative one, which must come out in full, then large positives.
        send_number(itoa_pkg::KIND_DEC, 32'hFFFF_FFFF);
        send_number(itoa_pkg::KIND_DEC, 32'hFFFF_FFF6);
        send_number(itoa_pkg::KIND_DEC, 32'h8000_0000);
        send_number(itoa_pkg::KIND_DEC, 32'h8000_0001);
        send_number(itoa_pkg::KIND_DEC, 32'h7FFF_FFFF);
        send_number(itoa_pkg::KIND_DEC, 32'd1000000000);
        // Octal reads the same words as unsigned; the top digit holds only two bits.
        send_number(itoa_pkg::KIND_OCT, 32'hFFFF_FFFF);
        send_number(itoa_pkg::KIND_OCT, 32'h8000_0000);
        send_number(itoa_pkg::KIND_OCT, 32'h7FFF_FFFF);
        send_number(itoa_pkg::KIND_OCT, 32'h4000_0000);
        send_number(itoa_pkg::KIND_OCT, 32'h3FFF_FFFF);
        // Alternating bit patterns in both formats.
        send_number(itoa_pkg::KIND_DEC, 32'hAAAA_AAAA);
        send_number(itoa_pkg::KIND_DEC, 32'h5555_5555);
        send_number(itoa_pkg::KIND_OCT, 32'hAAAA_AAAA);
        send_number(itoa_pkg::KIND_OCT, 32'h5555_5555);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Midway the sender waits for the block to run completely dry.
            if (i == RANDOM_ITEMS / 2)
                wait_for_drain();
            send_number($urandom_range(0, 1) ? itoa_pkg::KIND_OCT : itoa_pkg::KIND_DEC,
                        random_word());
        end

        wait_for_drain();
        // Any character the block still sends now has no number behind it.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && chars_owed == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
